// ===== hdl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, register codes and types for the stereo knee/tanh block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

  localparam int NUM_STAGES  = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 21;
  localparam int RATIO_W     = 17;
  localparam int THR_MAX_W   = 31;

  localparam int unsigned ROUND_Q16 = 32768;
  localparam logic [RATIO_W-1:0] UNITY_Q16 = 17'h10000;

  localparam logic [GAIN_W-1:0]     INPUT_GAIN_RST    = 21'd268435;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST     = 32'd1250000;
  localparam logic [RATIO_W-1:0]    INVERSE_RATIO_RST = 17'd6000;
  localparam logic [RATIO_W-1:0]    CLIP_MIX_RST      = 17'd5000;
  localparam logic [GAIN_W-1:0]     OUTPUT_GAIN_RST   = 21'd80000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INPUT_GAIN      = 3'd0,
    REG_THRESHOLD_LEVEL = 3'd1,
    REG_INVERSE_RATIO   = 3'd2,
    REG_CLIP_MIX        = 3'd3,
    REG_OUTPUT_GAIN     = 3'd4
  } cfg_reg_e;

  // effective settings, ratio and mix already clamped to one
  typedef struct packed {
    logic [GAIN_W-1:0]    input_gain;
    logic [THR_MAX_W-1:0] threshold;
    logic [RATIO_W-1:0]   inverse_ratio;
    logic [RATIO_W-1:0]   clip_mix;
    logic [RATIO_W-1:0]   clip_rest;
    logic [GAIN_W-1:0]    output_gain;
  } cfg_t;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

// ===== hdl/skt_if.sv =====
// ----------------------------------------------------------------------------
// skt_if
// Frame input, frame output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skt_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          last_frame;

  modport source (output valid, left_in, right_in, last_frame, input ready);
  modport sink   (input valid, left_in, right_in, last_frame, output ready);
endinterface

interface skt_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          saturated;
  logic                          last_out;

  modport source (output valid, left_out, right_out, saturated, last_out, input ready);
  modport sink   (input valid, left_out, right_out, saturated, last_out, output ready);
endinterface

interface skt_cfg_if;
  import skt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/skt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// skt_cfg_regs
// Register file for gains, knee threshold, ratio and clip mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_cfg_regs #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  skt_cfg_if.sink       cfg_i,
  output skt_pkg::cfg_t cfg_o
);
  import skt_pkg::*;

  localparam int F = SAMPLE_BITS - 1;

  logic [GAIN_W-1:0]  input_gain_q;
  logic [F-1:0]       threshold_q;
  logic [RATIO_W-1:0] inverse_ratio_q;
  logic [RATIO_W-1:0] clip_mix_q;
  logic [GAIN_W-1:0]  output_gain_q;
  logic [RATIO_W-1:0] ratio_eff;
  logic [RATIO_W-1:0] mix_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_gain_q    <= INPUT_GAIN_RST;
      threshold_q     <= THRESHOLD_RST[F-1:0];
      inverse_ratio_q <= INVERSE_RATIO_RST;
      clip_mix_q      <= CLIP_MIX_RST;
      output_gain_q   <= OUTPUT_GAIN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_INPUT_GAIN:      input_gain_q    <= cfg_i.data[GAIN_W-1:0];
        REG_THRESHOLD_LEVEL: threshold_q     <= cfg_i.data[F-1:0];
        REG_INVERSE_RATIO:   inverse_ratio_q <= cfg_i.data[RATIO_W-1:0];
        REG_CLIP_MIX:        clip_mix_q      <= cfg_i.data[RATIO_W-1:0];
        REG_OUTPUT_GAIN:     output_gain_q   <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // anything at or above one is used as one
  assign ratio_eff = inverse_ratio_q[RATIO_W-1] ? UNITY_Q16 : inverse_ratio_q;
  assign mix_eff   = clip_mix_q[RATIO_W-1] ? UNITY_Q16 : clip_mix_q;

  always_comb begin
    cfg_o.input_gain    = input_gain_q;
    cfg_o.threshold     = THR_MAX_W'(threshold_q);
    cfg_o.inverse_ratio = ratio_eff;
    cfg_o.clip_mix      = mix_eff;
    cfg_o.clip_rest     = UNITY_Q16 - mix_eff;
    cfg_o.output_gain   = output_gain_q;
  end

endmodule

// ===== hdl/skt_tanh_rom.sv =====
// ----------------------------------------------------------------------------
// skt_tanh_rom
// tanh table over [0, 8.0], built at elaboration, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_tanh_rom #(
  parameter int SAMPLE_BITS      = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [$clog2(TANH_TABLE_DEPTH+1)-1:0]  idx_i,
  input  logic                                   over_i,
  output logic [SAMPLE_BITS-1:0]                 t0_o,
  output logic [SAMPLE_BITS-1:0]                 t1_o
);
  import skt_pkg::*;

  localparam int F  = SAMPLE_BITS - 1;
  localparam int IW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
  localparam logic [63:0] A_Q30   = (64'd16 << 30) / TANH_TABLE_DEPTH;
  localparam logic [IW-1:0] LAST_IDX = IW'(TANH_TABLE_DEPTH);

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-16/depth) in Q30, truncated series
  function automatic logic [63:0] calc_r();
    logic [63:0] term;
    logic [63:0] sum;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * A_Q30) >> 30, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] R_Q30 = calc_r();

  function automatic logic [63:0] tanh_entry(input int i);
    logic [63:0] u;
    logic [63:0] den;
    u = ONE_Q30;
    for (int j = 1; j <= i; j++) begin
      u = (u * R_Q30 + (64'd1 << 29)) >> 30;
    end
    den = ONE_Q30 + u;
    return udiv(((ONE_Q30 - u) << F) + (den >> 1), den);
  endfunction

  logic [SAMPLE_BITS-1:0] rom_tbl [TANH_TABLE_DEPTH+1];
  logic [SAMPLE_BITS-1:0] t0_q;
  logic [SAMPLE_BITS-1:0] t1_q;

  for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_entry
    assign rom_tbl[gi] = SAMPLE_BITS'(tanh_entry(gi));
  end

  // past the table end both taps are the last entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q <= over_i ? rom_tbl[LAST_IDX] : rom_tbl[idx_i];
      t1_q <= over_i ? rom_tbl[LAST_IDX] : rom_tbl[idx_i + IW'(1)];
    end
  end

  assign t0_o = t0_q;
  assign t1_o = t1_q;

endmodule

// ===== hdl/skt_channel.sv =====
// ----------------------------------------------------------------------------
// skt_channel
// One channel: gain, soft knee, tanh blend, output gain, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_channel #(
  parameter int SAMPLE_BITS      = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  skt_pkg::stage_en_t     en_i,
  input  skt_pkg::cfg_t          cfg_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   sat_o
);
  import skt_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int F      = S - 1;
  localparam int GW     = S + 5;
  localparam int IW     = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int GSUM_W = S + 22;
  localparam int SSUM_W = GW + 17;
  localparam int POS_W  = F + 3 + IW;
  localparam int HSUM_W = S + 18;
  localparam int YSUM_W = GW + 18;
  localparam int ZSUM_W = GW + 22;
  localparam int ZW     = GW + 6;
  localparam logic [S-1:0] LIM_POS = {1'b0, {F{1'b1}}};
  localparam logic [S-1:0] LIM_NEG = {1'b1, {F{1'b0}}};

  // stage A: magnitude and input gain
  logic              neg_a;
  logic [S-1:0]      mag_a;
  logic [GSUM_W-1:0] g_sum;
  logic              neg_a_q;
  logic [GW-1:0]     g_a_q;

  assign neg_a = sample_i[S-1];
  assign mag_a = neg_a ? (~sample_i + 1'b1) : sample_i;
  assign g_sum = GSUM_W'(mag_a) * GSUM_W'(cfg_i.input_gain) + GSUM_W'(ROUND_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      neg_a_q <= neg_a;
      g_a_q   <= g_sum[GW+15:16];
    end
  end

  // stage B: knee compare, soft value, table position
  logic [GW-1:0]     thr_g;
  logic [SSUM_W-1:0] s_sum;
  logic [POS_W-1:0]  pos_b;
  logic              neg_b_q;
  logic              gt_b_q;
  logic [GW-1:0]     g_b_q;
  logic [GW-1:0]     s_b_q;
  logic [IW-1:0]     idx_b_q;
  logic [15:0]       frac_b_q;
  logic              over_b_q;

  assign thr_g = GW'(cfg_i.threshold[F-1:0]);
  assign s_sum = SSUM_W'(g_a_q - thr_g) * SSUM_W'(cfg_i.inverse_ratio)
               + SSUM_W'(ROUND_Q16);
  assign pos_b = POS_W'(g_a_q[F+2:0]) * POS_W'(TANH_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      neg_b_q  <= neg_a_q;
      gt_b_q   <= g_a_q > thr_g;
      g_b_q    <= g_a_q;
      s_b_q    <= thr_g + s_sum[GW+15:16];
      idx_b_q  <= pos_b[POS_W-1:F+3];
      frac_b_q <= pos_b[F+2:F-13];
      over_b_q <= |g_a_q[GW-1:F+3];
    end
  end

  // stage C: table read
  logic [S-1:0]  t0_c;
  logic [S-1:0]  t1_c;
  logic          neg_c_q;
  logic          gt_c_q;
  logic [GW-1:0] g_c_q;
  logic [GW-1:0] s_c_q;
  logic [15:0]   frac_c_q;

  skt_tanh_rom #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en_i[2]),
    .idx_i  (idx_b_q),
    .over_i (over_b_q),
    .t0_o   (t0_c),
    .t1_o   (t1_c)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      neg_c_q  <= neg_b_q;
      gt_c_q   <= gt_b_q;
      g_c_q    <= g_b_q;
      s_c_q    <= s_b_q;
      frac_c_q <= frac_b_q;
    end
  end

  // stage D: interpolation
  logic [HSUM_W-1:0] h_sum;
  logic              neg_d_q;
  logic              gt_d_q;
  logic [GW-1:0]     g_d_q;
  logic [GW-1:0]     s_d_q;
  logic [S-1:0]      h_d_q;

  assign h_sum = HSUM_W'(t0_c) * HSUM_W'(UNITY_Q16 - {1'b0, frac_c_q})
               + HSUM_W'(t1_c) * HSUM_W'(frac_c_q) + HSUM_W'(ROUND_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      neg_d_q <= neg_c_q;
      gt_d_q  <= gt_c_q;
      g_d_q   <= g_c_q;
      s_d_q   <= s_c_q;
      h_d_q   <= h_sum[S+15:16];
    end
  end

  // stage E: blend of soft and tanh values
  logic [YSUM_W-1:0] y_sum;
  logic              neg_e_q;
  logic [GW-1:0]     y_e_q;

  assign y_sum = YSUM_W'(s_d_q) * YSUM_W'(cfg_i.clip_rest)
               + YSUM_W'(h_d_q) * YSUM_W'(cfg_i.clip_mix) + YSUM_W'(ROUND_Q16);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      neg_e_q <= neg_d_q;
      y_e_q   <= gt_d_q ? y_sum[GW+15:16] : g_d_q;
    end
  end

  // stage F: output gain, clamp, sign
  logic [ZSUM_W-1:0] z_sum;
  logic [ZW-1:0]     z_f;
  logic [ZW-1:0]     lim_f;
  logic              sat_f;
  logic [S-1:0]      zc_f;
  logic [S-1:0]      out_q;
  logic              sat_q;

  assign z_sum = ZSUM_W'(y_e_q) * ZSUM_W'(cfg_i.output_gain) + ZSUM_W'(ROUND_Q16);
  assign z_f   = z_sum[ZSUM_W-1:16];
  assign lim_f = neg_e_q ? ZW'(LIM_NEG) : ZW'(LIM_POS);
  assign sat_f = z_f > lim_f;
  assign zc_f  = sat_f ? lim_f[S-1:0] : z_f[S-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      out_q <= neg_e_q ? (~zc_f + 1'b1) : zc_f;
      sat_q <= sat_f;
    end
  end

  assign sample_o = out_q;
  assign sat_o    = sat_q;

endmodule

// ===== hdl/stereo_knee_tanh_distortion.sv =====
// ----------------------------------------------------------------------------
// stereo_knee_tanh_distortion
// Stereo soft-knee compressor blended with a tanh clipper. Takes one frame per
// clock unless the output stalls it. Input gain, knee/table position, tanh
// table read, interpolation, blend and output gain/saturation are one register
// stage each, for both channels side by side. Backpressure on the output holds
// the pipeline in place; empty stages still fill while the output is stalled.
// The tanh table has TANH_TABLE_DEPTH+1 constant entries. Register writes are
// always taken and should only be made while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_knee_tanh_distortion #(
  parameter int SAMPLE_BITS      = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o,
  skt_cfg_if.sink   cfg_i
);
  import skt_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  cfg_t                   cfg;
  stage_en_t              en;
  logic [NUM_STAGES-1:0]  v_q;
  logic [NUM_STAGES-1:0]  v_d;
  logic [NUM_STAGES-1:0]  last_q;
  logic [SAMPLE_BITS-1:0] left_z;
  logic [SAMPLE_BITS-1:0] right_z;
  logic                   sat_l;
  logic                   sat_r;

  skt_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= in_i.last_frame;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  skt_channel #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_left (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .sample_i (in_i.left_in),
    .sample_o (left_z),
    .sat_o    (sat_l)
  );

  skt_channel #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_right (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .sample_i (in_i.right_in),
    .sample_o (right_z),
    .sat_o    (sat_r)
  );

  assign in_i.ready      = en[0];
  assign out_o.valid     = v_q[NUM_STAGES-1];
  assign out_o.left_out  = left_z;
  assign out_o.right_out = right_z;
  assign out_o.saturated = sat_l | sat_r;
  assign out_o.last_out  = last_q[NUM_STAGES-1];

  // a ready sink never stalls the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output ready");

  // an accepted beat lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted beat lost at pipeline entry");

  // a saturation flag comes with a clamped sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (left_z == SAMPLE_MAX) || (left_z == SAMPLE_MIN) ||
      (right_z == SAMPLE_MAX) || (right_z == SAMPLE_MIN))
    else $error("saturation flag without clamped sample");

endmodule
